// ===== hdl/tksi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_pkg - shared types and constants for the top-K insertion keeper
// Slot and link types used by the cell chain, the result word type and the
// default list depth.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int TKSI_SLOTS_DEFAULT = 128;
    localparam int SCORE_W            = 16;
    localparam int TAG_W              = 16;

    localparam logic [SCORE_W-1:0] SCORE_EMPTY = {SCORE_W{1'b1}};

    // one list entry
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
    } slot_t;

    // what a cell shows its right-hand neighbor
    typedef struct packed {
        slot_t slot;
        logic  gt;      // stored score > offered score
    } link_t;

    // offer broadcast to every cell
    typedef struct packed {
        logic  load;    // insert this cycle
        slot_t item;
    } offer_t;

    // one result word
    typedef struct packed {
        logic               accepted;
        logic               released_valid;
        logic [TAG_W-1:0]   released_tag;
        logic [SCORE_W-1:0] best_score;
        logic [TAG_W-1:0]   best_tag;
        logic [SCORE_W-1:0] worst_score;
    } result_t;

endpackage

// ===== hdl/tksi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_cell - one slot of the sorted insertion chain
// Holds one entry. On an insert it either keeps its entry, takes the
// offered entry, or takes its left neighbor's entry (shift toward the tail).
// ----------------------------------------------------------------------------
module tksi_cell
    import tksi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  offer_t offer,
    input  link_t  prev,      // left neighbor, gt tied low for the head cell
    output link_t  link,      // this cell's entry and compare flag
    output slot_t  slot_next  // entry after this cycle
);

    slot_t slot_reg;

    // compare against the broadcast score
    assign link.slot = slot_reg;
    assign link.gt   = (slot_reg.score > offer.item.score);

    // neighbor larger too: entry moves in from the left; else, if this entry is larger, the offer lands here
    always_comb
    begin
        slot_next = slot_reg;
        if (offer.load)
        begin
            if (prev.gt)
                slot_next = prev.slot;
            else if (link.gt)
                slot_next = offer.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg.valid <= 1'b0;
            slot_reg.tag   <= '0;
            slot_reg.score <= SCORE_EMPTY;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ===== hdl/tksi_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_out_queue - two-entry output buffer
// Output register plus a skid entry, so a new word can be taken while the
// previous result waits on the master side.
// ----------------------------------------------------------------------------
module tksi_out_queue
    import tksi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;
    logic    head_valid_reg;
    logic    head_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    pop;

    assign pop        = head_valid_reg && pop_ready;
    assign push_ready = !skid_valid_reg;
    assign pop_valid  = head_valid_reg;
    assign pop_data   = head_reg;

    // queue update
    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                head_next = push_data;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hdl/top_k_sorted_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_core - keeps the SLOTS lowest-score entries in order
// A chain of cells, one per slot, ordered best to worst score.
// ----------------------------------------------------------------------------
// Use:
//   s_tdata carries an offered entry (score, tag). Each accepted word makes
//   exactly one result word on the m side.
//   An offer whose score is strictly below the tail score is inserted: every
//   cell compares against the broadcast score in the same cycle and the
//   entries behind the insert point shift one cell toward the tail, so the
//   tail entry drops out and its tag is reported as released.
//   Otherwise the list is unchanged and the offered tag is released.
// Timing:
//   One offer per cycle while s_tready is high; the list update happens at the accepting edge.
//   The result is on m_tvalid the cycle after acceptance when no earlier result is waiting.
//   Cycle time is set by the broadcast compare across the cell row.
// Reset:
//   All slots empty (score all ones, tag zero, not valid); output empty.
// Stall:
//   A two-word output buffer holds results while m_tready is low;
//   s_tready drops once both entries are occupied.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_core
    import tksi_pkg::*;
#(
    parameter int SLOTS = TKSI_SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] new_score, [31:16] new_tag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] released_tag, [31:16] best_score,
                                   // [47:32] best_tag, [63:48] worst_score
    output logic [1:0]  m_tuser    // [0] accepted, [1] released_valid
);

    offer_t  offer;
    link_t   chain [SLOTS+1];
    slot_t   nxt   [SLOTS];
    slot_t   tail;
    logic    s_fire;
    logic    take;
    result_t res;
    result_t out_word;

    assign s_fire = s_tvalid && s_tready;

    // broadcast the offer; insert only when it beats the tail
    assign tail             = chain[SLOTS].slot;
    assign take             = chain[SLOTS].gt;
    assign offer.load       = s_fire && take;
    assign offer.item.valid = 1'b1;
    assign offer.item.score = s_tdata[SCORE_W-1:0];
    assign offer.item.tag   = s_tdata[SCORE_W +: TAG_W];

    // head cell sees no larger neighbor
    assign chain[0].slot = '0;
    assign chain[0].gt   = 1'b0;

    // cell row
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        tksi_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .offer     (offer),
            .prev      (chain[i]),
            .link      (chain[i+1]),
            .slot_next (nxt[i])
        );
    end

    // result word from the tail (or the offer on a reject) before and the ends after the update
    always_comb
    begin
        res.accepted       = take;
        res.released_valid = take ? tail.valid : 1'b1;
        res.released_tag   = take ? tail.tag : offer.item.tag;
        res.best_score     = nxt[0].score;
        res.best_tag       = nxt[0].tag;
        res.worst_score    = nxt[SLOTS-1].score;
    end

    tksi_out_queue u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_fire),
        .push_data  (res),
        .push_ready (s_tready),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_data   (out_word)
    );

    assign m_tdata = {out_word.worst_score, out_word.best_tag,
                      out_word.best_score, out_word.released_tag};
    assign m_tuser = {out_word.released_valid, out_word.accepted};

`ifndef NO_ASSERTIONS
    // back pressure only comes from a full buffer holding a result
    a_ready_only_when_holding: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with empty output");

    // list ends stay ordered
    a_ends_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        chain[1].slot.score <= chain[SLOTS].slot.score)
        else $error("head score above tail score");

    // a rejected or absent offer leaves the tail alone
    a_reject_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !offer.load |=> $stable(chain[SLOTS].slot))
        else $error("tail changed without an insert");

    // the tail score never grows
    a_tail_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        offer.load |=> chain[SLOTS].slot.score <= $past(chain[SLOTS].slot.score))
        else $error("tail score increased");
`endif

endmodule

// ===== dv/tb_top_k_sorted_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_insert_core - self-checking bench for the top-K keeper
// Offers scored entries on the s side and checks every result word on the
// m side against a local model of the sorted list. A short directed table
// covers the extremes, ties and the reject/empty-eviction cases. Random
// offers then fill and churn the list through four flow-control phases.
// ----------------------------------------------------------------------------
module tb_top_k_sorted_insert_core;
    import tksi_pkg::*;

    localparam int LIST_DEPTH = TKSI_SLOTS_DEFAULT;
    localparam int PHASE_OFFERS = 412;
    localparam int DRAIN_CYCLES = 10;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               typed;
        result_t            want;
    } offer_row_t;

    localparam int DIR_ROWS = 16;
    localparam offer_row_t DIR_TABLE [DIR_ROWS] = '{
        // reject of all-ones score on an empty list: first slot still empty
        '{16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}},
        // lowest score evicts an empty slot, nothing to free
        '{16'h0000, 16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}},
        // equal score lands behind the older entry
        '{16'h0000, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}},
        '{16'hFFFE, 16'hA5A5, 1'b0, '0},
        '{16'hFFFF, 16'h5A5A, 1'b1, '{1'b0, 1'b1, 16'h5A5A, 16'h0000, 16'h0000, 16'hFFFF}},
        '{16'h8000, 16'h8000, 1'b0, '0},
        '{16'h7FFF, 16'h7FFF, 1'b0, '0},
        '{16'h0001, 16'h1234, 1'b0, '0},
        '{16'h0001, 16'h4321, 1'b0, '0},
        '{16'h00FF, 16'hFF00, 1'b0, '0},
        '{16'hFF00, 16'h00FF, 1'b0, '0},
        '{16'hFFFE, 16'h0001, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 1'b0, '0},
        '{16'h0000, 16'h0F0F, 1'b0, '0},
        '{16'hFFFF, 16'h0000, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] new_score, [31:16] new_tag
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [15:0] released_tag, [31:16] best_score,
                            // [47:32] best_tag, [63:48] worst_score
    logic [1:0]  m_tuser;   // [0] accepted, [1] released_valid

    // local copy of the list, slot 0 best
    slot_t   list_slot [LIST_DEPTH];
    result_t pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_cnt;
    int word_cnt;
    int accept_cnt;
    int evict_cnt;
    int reject_cnt;

    top_k_sorted_insert_core #(
        .SLOTS(LIST_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // insert an offer into the local list and return the result word
    function automatic result_t insert_offer(input logic [SCORE_W-1:0] score,
                                             input logic [TAG_W-1:0]   tag);
        result_t r;
        int      pos;
        r = '0;
        if (score < list_slot[LIST_DEPTH-1].score)
        begin
            r.accepted       = 1'b1;
            r.released_valid = list_slot[LIST_DEPTH-1].valid;
            r.released_tag   = list_slot[LIST_DEPTH-1].tag;
            pos = LIST_DEPTH - 1;
            // strictly larger scores move back; ties keep the older entry ahead
            while (pos > 0 && list_slot[pos-1].score > score)
            begin
                list_slot[pos] = list_slot[pos-1];
                pos--;
            end
            list_slot[pos].valid = 1'b1;
            list_slot[pos].tag   = tag;
            list_slot[pos].score = score;
        end
        else
        begin
            r.released_valid = 1'b1;
            r.released_tag   = tag;
        end
        r.best_score  = list_slot[0].score;
        r.best_tag    = list_slot[0].tag;
        r.worst_score = list_slot[LIST_DEPTH-1].score;
        return r;
    endfunction

    // pick a random score, biased toward the interesting regions of the list
    function automatic logic [SCORE_W-1:0] pick_score();
        int                 kind;
        logic [SCORE_W-1:0] worst;
        kind  = $urandom_range(0, 99);
        worst = list_slot[LIST_DEPTH-1].score;
        if (kind < 30)
            return SCORE_W'($urandom_range(0, 65535));
        else if (kind < 55)
            return (worst == 0) ? '0 : SCORE_W'($urandom_range(0, worst - 1));
        else if (kind < 70)
            return list_slot[$urandom_range(0, LIST_DEPTH - 1)].score;   // tie
        else if (kind < 80)
            return worst;                                               // equal to tail
        else if (kind < 88)
            return SCORE_W'($urandom_range(0, 15));
        else if (kind < 94)
            return SCORE_EMPTY;
        else
            return SCORE_W'(SCORE_EMPTY - 1);
    endfunction

    // send one offer word; entered and left at a falling edge
    task automatic send_offer(input logic [SCORE_W-1:0] score,
                              input logic [TAG_W-1:0]   tag,
                              input logic               typed,
                              input result_t            want);
        result_t model;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, score};
        do
            @(posedge clk);
        while (!s_tready);
        model = insert_offer(score, tag);
        pending_results.push_back(typed ? want : model);
        @(negedge clk);
    endtask

    // receiver back-pressure
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accepted       = m_tuser[0];
            got.released_valid = m_tuser[1];
            got.released_tag   = m_tdata[15:0];
            got.best_score     = m_tdata[31:16];
            got.best_tag       = m_tdata[47:32];
            got.worst_score    = m_tdata[63:48];
            word_cnt++;
            if (got.accepted)
                accept_cnt++;
            else
                reject_cnt++;
            if (got.accepted && got.released_valid)
                evict_cnt++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word acc=%0b rv=%0b rtag=%h best=%h/%h worst=%h",
                         $time, got.accepted, got.released_valid, got.released_tag,
                         got.best_score, got.best_tag, got.worst_score);
                fail_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.accepted !== want.accepted
                    || got.released_valid !== want.released_valid
                    || got.released_tag !== want.released_tag
                    || got.best_score !== want.best_score
                    || got.best_tag !== want.best_tag
                    || got.worst_score !== want.worst_score)
                begin
                    $display("%0t: mismatch exp acc=%0b rv=%0b rtag=%h best=%h/%h worst=%h",
                             $time, want.accepted, want.released_valid, want.released_tag,
                             want.best_score, want.best_tag, want.worst_score);
                    $display("%0t:          got acc=%0b rv=%0b rtag=%h best=%h/%h worst=%h",
                             $time, got.accepted, got.released_valid, got.released_tag,
                             got.best_score, got.best_tag, got.worst_score);
                    fail_cnt++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int n;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_cnt       = 0;
        word_cnt       = 0;
        accept_cnt     = 0;
        evict_cnt      = 0;
        reject_cnt     = 0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            list_slot[i].valid = 1'b0;
            list_slot[i].tag   = '0;
            list_slot[i].score = SCORE_EMPTY;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < DIR_ROWS; i++)
            send_offer(DIR_TABLE[i].score, DIR_TABLE[i].tag, DIR_TABLE[i].typed,
                       DIR_TABLE[i].want);

        // random offers over four flow-control phases
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (n = 0; n < PHASE_OFFERS; n++)
                send_offer(pick_score(), TAG_W'($urandom_range(0, 65535)), 1'b0, '0);
        end
        s_tvalid       <= 1'b0;
        recv_stall_pct = 0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result words: %0d accepted (%0d evicting a held entry), %0d rejected",
                 word_cnt, accept_cnt, evict_cnt, reject_cnt);
        $display("List depth %0d, directed table plus random offers over four stall phases",
                 LIST_DEPTH);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
